// ===== src/msd_pkg.sv =====
// Shared constants, result type and helpers for the message stream deframer.
// No dependencies; used by the top level and its port checker.
package msd_pkg;

    // Payload length register width (low bits of the 32-bit big-endian length)
    localparam int LENGTH_BITS = 32;

    // Number of length bytes ahead of each length-prefixed frame
    localparam logic [2:0] LENGTH_BYTES = 3'd4;

    // Held head bytes before the mode is forced
    localparam int HEAD_DEPTH = 7;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;
    // Largest number of results one byte step can produce
    localparam int STEP_MAX   = 3;

    // Characters of interest
    localparam logic [7:0] CH_LT    = 8'h3C;   // '<'
    localparam logic [7:0] CH_GT    = 8'h3E;   // '>'
    localparam logic [7:0] CH_SLASH = 8'h2F;   // '/'
    localparam logic [7:0] CH_NINE  = 8'h39;   // '9'
    localparam logic [7:0] CH_H_LO  = 8'h68;   // 'h'
    localparam logic [7:0] CH_H_UP  = 8'h48;   // 'H'

    // Framing mode codes
    localparam logic [1:0] MODE_UNDECIDED = 2'd0;
    localparam logic [1:0] MODE_PREFIX    = 2'd1;
    localparam logic [1:0] MODE_TAG       = 2'd2;

    // Tag scanner state codes
    localparam logic [2:0] TS_OUTSIDE    = 3'd0;
    localparam logic [2:0] TS_OPEN       = 3'd1;
    localparam logic [2:0] TS_OPEN_SLASH = 3'd2;
    localparam logic [2:0] TS_BODY       = 3'd3;
    localparam logic [2:0] TS_LT         = 3'd4;
    localparam logic [2:0] TS_LT_SL      = 3'd5;
    localparam logic [2:0] TS_LT_SL_H    = 3'd6;
    localparam logic [2:0] TS_WAIT_GT    = 3'd7;

    // Partial "<h9" match progress while outside a message
    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_LT   = 2'd1;
    localparam logic [1:0] HOLD_LT_H = 2'd2;

    // Framing kind carried with every result
    localparam logic KIND_PREFIX = 1'b0;
    localparam logic KIND_TAG    = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       sop;
        logic       eop;
        logic       kind;
        logic       last;
    } result_t;

    function automatic logic is_h(input logic [7:0] b);
        return (b == CH_H_LO) || (b == CH_H_UP);
    endfunction

endpackage

// ===== src/message_stream_deframer.sv =====
// Message stream deframer: length-prefixed or tag-delimited framing, one byte per transaction.
// Depends on msd_pkg for constants, the result type and the 'h' test.
//
// Each slave transaction carries one received byte (tuser = 0) or a connection-closed
// event (tuser = 1) that returns the framing logic to its start state; results already
// queued are still delivered. The first bytes of a connection are held in a 7-byte head.
// Once bytes 4..6 read "<h9" (either case of h) the stream is length-prefixed: a 4-byte
// big-endian length, then that many payload bytes; a zero length is skipped. If the stream
// opens with "<h9", or 7 bytes arrive without the prefix pattern, it is tag-delimited: a
// message runs from "<h9" to a self-closing "/>" or to the '>' after "</h9", and bytes
// outside a message are dropped. Every message byte leaves as one master transaction with
// start (tuser[0]), end (tlast), kind (tuser[1]) and a last-of-input mark (tuser[2]).
//
// Rate: one input byte per cycle when the master side keeps up. A result passes through
// the input register, then the result queue, before it leaves. The master port moves
// at most one result per cycle, so a byte that completes "<h9" (three results) leaves
// two extra results waiting; the queue absorbs them and the input only stalls once more
// than five results are queued. When the mode is decided the held head (3 or 7 bytes) is
// replayed through the same byte step, one byte per cycle, and no input is taken during
// those cycles. The byte step only runs while the 8-entry result queue has room for three.
module message_stream_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
    input  logic [0:0] s_axis_tuser,    // [0] req_type
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_byte
    output logic [2:0] m_axis_tuser,    // [0] msg_start, [1] framing_kind, [2] run_last
    output logic       m_axis_tlast     // msg_end
);

    localparam int LB = msd_pkg::LENGTH_BITS;

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic       in_req_reg;
    logic [7:0] in_byte_reg;

    // Framing state
    logic [1:0]    mode_reg, mode_next;
    logic [7:0]    head_reg [msd_pkg::HEAD_DEPTH];
    logic [2:0]    head_count_reg, head_count_next;
    logic [LB-1:0] len_shift_reg, len_shift_next;
    logic [2:0]    len_seen_reg, len_seen_next;
    logic [LB-1:0] payload_left_reg, payload_left_next;
    logic [2:0]    tag_state_reg, tag_state_next;
    logic [1:0]    open_hold_reg, open_hold_next;
    logic          held_upper_reg, held_upper_next;

    // Head replay sequencer
    logic       replay_active_reg, replay_active_next;
    logic [2:0] replay_idx_reg, replay_idx_next;
    logic [2:0] replay_last_reg, replay_last_next;

    // Result queue
    msd_pkg::result_t              fifo_mem [msd_pkg::FIFO_DEPTH];
    logic [msd_pkg::FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [msd_pkg::FIFO_CW-1:0]   count_reg;
    logic                          tail_open_reg, tail_open_next;

    // Step signals
    logic             space_ok, in_fire, replay_fire, step_fire, src_final;
    logic [7:0]       step_byte;
    logic             head_we;
    logic [2:0]       cnt_new;
    logic [7:0]       head_view [msd_pkg::HEAD_DEPTH];
    logic             is_pre, is_tag;
    logic [LB+7:0]    shift_cat;
    logic [LB-1:0]    shift_new, pl_dec;
    msd_pkg::result_t res [msd_pkg::STEP_MAX];
    logic [1:0]       res_n;
    logic             tail_close, pop;
    logic [msd_pkg::FIFO_CW-1:0] push_n;

    // Hold the step while the queue cannot take a full "<h9" burst
    assign space_ok    = count_reg <= msd_pkg::FIFO_CW'(msd_pkg::FIFO_DEPTH - msd_pkg::STEP_MAX);
    assign replay_fire = replay_active_reg && space_ok;
    assign in_fire     = in_valid_reg && !replay_active_reg && space_ok;
    assign step_fire   = replay_fire || in_fire;
    assign src_final   = !replay_active_reg || (replay_idx_reg == replay_last_reg);
    assign step_byte   = replay_active_reg ? head_reg[replay_idx_reg] : in_byte_reg;

    assign s_axis_tready = !in_valid_reg || in_fire;

    // Byte step: one byte through the framing logic, up to three results
    always_comb
    begin
        mode_next          = mode_reg;
        head_count_next    = head_count_reg;
        len_shift_next     = len_shift_reg;
        len_seen_next      = len_seen_reg;
        payload_left_next  = payload_left_reg;
        tag_state_next     = tag_state_reg;
        open_hold_next     = open_hold_reg;
        held_upper_next    = held_upper_reg;
        replay_active_next = replay_active_reg;
        replay_idx_next    = replay_idx_reg;
        replay_last_next   = replay_last_reg;
        head_we            = 1'b0;
        res_n              = 2'd0;
        for (int i = 0; i < msd_pkg::STEP_MAX; i++)
        begin
            res[i] = '0;
        end
        head_view = head_reg;
        head_view[head_count_reg] = step_byte;
        cnt_new   = head_count_reg + 3'd1;
        is_pre    = (cnt_new == 3'(msd_pkg::HEAD_DEPTH)) && (head_view[4] == msd_pkg::CH_LT)
                    && msd_pkg::is_h(head_view[5]) && (head_view[6] == msd_pkg::CH_NINE);
        is_tag    = (cnt_new == 3'(msd_pkg::HEAD_DEPTH))
                    || ((cnt_new >= 3'd3) && (head_view[0] == msd_pkg::CH_LT)
                        && msd_pkg::is_h(head_view[1]) && (head_view[2] == msd_pkg::CH_NINE));
        shift_cat = {len_shift_reg, step_byte};
        shift_new = shift_cat[LB-1:0];
        pl_dec    = payload_left_reg - LB'(1);

        if (step_fire)
        begin
            if (replay_active_reg)
            begin
                // Advance the replay pointer; drop out after the last held byte
                if (src_final)
                begin
                    replay_active_next = 1'b0;
                end
                else
                begin
                    replay_idx_next = replay_idx_reg + 3'd1;
                end
            end

            if (!replay_active_reg && in_req_reg)
            begin
                // Connection closed: back to the start state
                mode_next         = msd_pkg::MODE_UNDECIDED;
                head_count_next   = 3'd0;
                len_shift_next    = '0;
                len_seen_next     = 3'd0;
                payload_left_next = '0;
                tag_state_next    = msd_pkg::TS_OUTSIDE;
                open_hold_next    = msd_pkg::HOLD_NONE;
                held_upper_next   = 1'b0;
            end
            else if (mode_reg == msd_pkg::MODE_PREFIX)
            begin
                if (len_seen_reg < msd_pkg::LENGTH_BYTES)
                begin
                    len_shift_next = shift_new;
                    len_seen_next  = len_seen_reg + 3'd1;
                    if (len_seen_reg == msd_pkg::LENGTH_BYTES - 3'd1)
                    begin
                        payload_left_next = shift_new;
                        // Skip a zero-length frame
                        if (shift_new == '0)
                        begin
                            len_seen_next = 3'd0;
                        end
                    end
                end
                else
                begin
                    res[0].data = step_byte;
                    res[0].sop  = payload_left_reg == len_shift_reg;
                    res[0].eop  = pl_dec == '0;
                    res[0].kind = msd_pkg::KIND_PREFIX;
                    res_n       = 2'd1;
                    payload_left_next = pl_dec;
                    if (pl_dec == '0)
                    begin
                        len_seen_next  = 3'd0;
                        len_shift_next = '0;
                    end
                end
            end
            else if (mode_reg == msd_pkg::MODE_TAG)
            begin
                case (tag_state_reg)
                    msd_pkg::TS_OUTSIDE:
                    begin
                        case (open_hold_reg)
                            msd_pkg::HOLD_NONE:
                            begin
                                if (step_byte == msd_pkg::CH_LT)
                                begin
                                    open_hold_next = msd_pkg::HOLD_LT;
                                end
                            end
                            msd_pkg::HOLD_LT:
                            begin
                                if (msd_pkg::is_h(step_byte))
                                begin
                                    open_hold_next  = msd_pkg::HOLD_LT_H;
                                    held_upper_next = step_byte == msd_pkg::CH_H_UP;
                                end
                                else if (step_byte != msd_pkg::CH_LT)
                                begin
                                    open_hold_next = msd_pkg::HOLD_NONE;
                                end
                            end
                            default:
                            begin
                                if (step_byte == msd_pkg::CH_NINE)
                                begin
                                    // Opening tag complete: release the held bytes
                                    res[0].data = msd_pkg::CH_LT;
                                    res[0].sop  = 1'b1;
                                    res[0].kind = msd_pkg::KIND_TAG;
                                    res[1].data = held_upper_reg ? msd_pkg::CH_H_UP
                                                                 : msd_pkg::CH_H_LO;
                                    res[1].kind = msd_pkg::KIND_TAG;
                                    res[2].data = msd_pkg::CH_NINE;
                                    res[2].kind = msd_pkg::KIND_TAG;
                                    res_n          = 2'd3;
                                    tag_state_next = msd_pkg::TS_OPEN;
                                    open_hold_next = msd_pkg::HOLD_NONE;
                                end
                                else
                                begin
                                    open_hold_next = (step_byte == msd_pkg::CH_LT)
                                                     ? msd_pkg::HOLD_LT : msd_pkg::HOLD_NONE;
                                end
                            end
                        endcase
                    end
                    msd_pkg::TS_OPEN, msd_pkg::TS_OPEN_SLASH:
                    begin
                        res[0].data = step_byte;
                        res[0].kind = msd_pkg::KIND_TAG;
                        res_n       = 2'd1;
                        if (step_byte == msd_pkg::CH_GT)
                        begin
                            res[0].eop     = tag_state_reg == msd_pkg::TS_OPEN_SLASH;
                            tag_state_next = (tag_state_reg == msd_pkg::TS_OPEN_SLASH)
                                             ? msd_pkg::TS_OUTSIDE : msd_pkg::TS_BODY;
                        end
                        else
                        begin
                            tag_state_next = (step_byte == msd_pkg::CH_SLASH)
                                             ? msd_pkg::TS_OPEN_SLASH : msd_pkg::TS_OPEN;
                        end
                    end
                    msd_pkg::TS_WAIT_GT:
                    begin
                        res[0].data = step_byte;
                        res[0].eop  = step_byte == msd_pkg::CH_GT;
                        res[0].kind = msd_pkg::KIND_TAG;
                        res_n       = 2'd1;
                        if (step_byte == msd_pkg::CH_GT)
                        begin
                            tag_state_next = msd_pkg::TS_OUTSIDE;
                        end
                    end
                    default:
                    begin
                        // Message body: track a possible "</h9"
                        res[0].data = step_byte;
                        res[0].kind = msd_pkg::KIND_TAG;
                        res_n       = 2'd1;
                        if (tag_state_reg == msd_pkg::TS_LT && step_byte == msd_pkg::CH_SLASH)
                        begin
                            tag_state_next = msd_pkg::TS_LT_SL;
                        end
                        else if (tag_state_reg == msd_pkg::TS_LT_SL
                                 && msd_pkg::is_h(step_byte))
                        begin
                            tag_state_next = msd_pkg::TS_LT_SL_H;
                        end
                        else if (tag_state_reg == msd_pkg::TS_LT_SL_H
                                 && step_byte == msd_pkg::CH_NINE)
                        begin
                            tag_state_next = msd_pkg::TS_WAIT_GT;
                        end
                        else
                        begin
                            tag_state_next = (step_byte == msd_pkg::CH_LT)
                                             ? msd_pkg::TS_LT : msd_pkg::TS_BODY;
                        end
                    end
                endcase
            end
            else
            begin
                // Mode undecided: hold the byte, then start a replay once decided
                head_we         = 1'b1;
                head_count_next = cnt_new;
                if (is_pre || is_tag)
                begin
                    mode_next          = is_pre ? msd_pkg::MODE_PREFIX : msd_pkg::MODE_TAG;
                    head_count_next    = 3'd0;
                    replay_active_next = 1'b1;
                    replay_idx_next    = 3'd0;
                    replay_last_next   = cnt_new - 3'd1;
                end
            end
        end

        // Mark the last result of the input transaction
        for (int i = 0; i < msd_pkg::STEP_MAX; i++)
        begin
            res[i].last = src_final && (res_n == 2'(i + 1));
        end
    end

    // A final replay step without results closes the result held at the queue tail
    assign tail_close = step_fire && src_final && (res_n == 2'd0) && tail_open_reg;

    always_comb
    begin
        tail_open_next = tail_open_reg;
        if (step_fire && res_n != 2'd0)
        begin
            tail_open_next = !src_final;
        end
        else if (tail_close)
        begin
            tail_open_next = 1'b0;
        end
    end

    assign in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;
    assign push_n        = step_fire ? msd_pkg::FIFO_CW'(res_n) : '0;
    assign pop           = m_axis_tvalid && m_axis_tready;

    // The queue tail may not leave while later replay bytes can still add to the transaction
    assign m_axis_tvalid = (count_reg > msd_pkg::FIFO_CW'(1))
                           || ((count_reg == msd_pkg::FIFO_CW'(1)) && !tail_open_reg);
    assign m_axis_tdata  = fifo_mem[rd_ptr_reg].data;
    assign m_axis_tuser  = {fifo_mem[rd_ptr_reg].last, fifo_mem[rd_ptr_reg].kind,
                            fifo_mem[rd_ptr_reg].sop};
    assign m_axis_tlast  = fifo_mem[rd_ptr_reg].eop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            mode_reg          <= msd_pkg::MODE_UNDECIDED;
            head_count_reg    <= 3'd0;
            len_shift_reg     <= '0;
            len_seen_reg      <= 3'd0;
            payload_left_reg  <= '0;
            tag_state_reg     <= msd_pkg::TS_OUTSIDE;
            open_hold_reg     <= msd_pkg::HOLD_NONE;
            held_upper_reg    <= 1'b0;
            replay_active_reg <= 1'b0;
            replay_idx_reg    <= 3'd0;
            replay_last_reg   <= 3'd0;
            wr_ptr_reg        <= '0;
            rd_ptr_reg        <= '0;
            count_reg         <= '0;
            tail_open_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg      <= in_valid_next;
            mode_reg          <= mode_next;
            head_count_reg    <= head_count_next;
            len_shift_reg     <= len_shift_next;
            len_seen_reg      <= len_seen_next;
            payload_left_reg  <= payload_left_next;
            tag_state_reg     <= tag_state_next;
            open_hold_reg     <= open_hold_next;
            held_upper_reg    <= held_upper_next;
            replay_active_reg <= replay_active_next;
            replay_idx_reg    <= replay_idx_next;
            replay_last_reg   <= replay_last_next;
            wr_ptr_reg        <= wr_ptr_reg + msd_pkg::FIFO_AW'(push_n);
            rd_ptr_reg        <= rd_ptr_reg + msd_pkg::FIFO_AW'(pop);
            count_reg         <= count_reg + push_n - msd_pkg::FIFO_CW'(pop);
            tail_open_reg     <= tail_open_next;
        end
    end

    // Payload storage: input byte, head bytes and queued results
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_req_reg  <= s_axis_tuser[0];
            in_byte_reg <= s_axis_tdata;
        end
        if (head_we)
        begin
            head_reg[head_count_reg] <= step_byte;
        end
        if (step_fire)
        begin
            for (int i = 0; i < msd_pkg::STEP_MAX; i++)
            begin
                if (2'(i) < res_n)
                begin
                    fifo_mem[wr_ptr_reg + msd_pkg::FIFO_AW'(i)] <= res[i];
                end
            end
        end
        if (tail_close)
        begin
            fifo_mem[wr_ptr_reg - msd_pkg::FIFO_AW'(1)].last <= 1'b1;
        end
    end

endmodule

// ===== src/msd_checker.sv =====
// Port-level checker for the message stream deframer, with its bind to the top level.
// Depends on msd_pkg for the delimiter characters.
module msd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A tag-delimited message opens with '<'
    a_tag_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1] |-> m_axis_tdata == msd_pkg::CH_LT)
        else $error("tag message does not start with '<'");

    // A tag-delimited message closes with '>'
    a_tag_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tuser[1] |-> m_axis_tdata == msd_pkg::CH_GT)
        else $error("tag message does not end with '>'");

    // The opening '<' is always followed by the rest of the tag from the same transaction
    a_tag_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1] |-> !m_axis_tuser[2])
        else $error("tag start marked as last result of its transaction");

endmodule

bind message_stream_deframer msd_checker u_msd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for message_stream_deframer: directed table, then random sessions.
// Depends on msd_pkg (codes, characters, result_t) and the deframer RTL; needs no other file.
module testbench;

    // Run shape
    localparam int IDLE_PCT     = 35;    // chance in a hundred that a side idles in a cycle
    localparam int RANDOM_ITEMS = 100;   // rough size of the random part
    localparam int CALM_FROM    = 60;    // sender offers back to back between these items
    localparam int CALM_TO      = 110;
    localparam int RX_CALM_FROM = 60;    // receiver keeps tready high between these results
    localparam int RX_CALM_TO   = 160;
    localparam int HOLD_AT_ITEM = 35;    // receiver holds off once this many items are in
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 16;    // input register and result queue plus a head replay, with margin
    localparam int STALL_LIMIT  = 1000;  // cycles with no transaction on either side
    localparam int REPORT_MAX   = 40;

    localparam logic [31:0] LEN_MASK = 32'((64'd1 << msd_pkg::LENGTH_BITS) - 64'd1);
    localparam msd_pkg::result_t NO_RESULT = '0;

    // One stimulus row: a received byte or a connection-closed event, with an optional
    // hand-typed expectation (none or a single result) that replaces the predicted one
    typedef struct packed {
        logic             close;
        logic [7:0]       data;
        logic             pinned;
        logic             pin_one;
        msd_pkg::result_t pin_res;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic [0:0] s_axis_tuser = 1'b0;    // [0] req_type
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [2:0] m_axis_tuser;           // [0] msg_start, [1] framing_kind, [2] run_last
    logic       m_axis_tlast;           // msg_end

    message_stream_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Directed part: tag framing with both cases of h, a self-closing and a closed message,
    // a broken opening that restarts on '<', the byte extremes, a connection close, then
    // length framing where the stream head doubles as the first frame, and a zero length
    stim_row_t directed_rows [29] = '{
        '{1'b0, msd_pkg::CH_LT,    1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_H_UP,  1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_NINE,  1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_SLASH, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_GT,    1'b1, 1'b1,
          '{msd_pkg::CH_GT, 1'b0, 1'b1, msd_pkg::KIND_TAG, 1'b1}},
        '{1'b0, msd_pkg::CH_LT,    1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_H_LO,  1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_LT,    1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_H_LO,  1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_NINE,  1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_GT,    1'b0, 1'b0, NO_RESULT},
        '{1'b0, 8'hFF,             1'b1, 1'b1,
          '{8'hFF, 1'b0, 1'b0, msd_pkg::KIND_TAG, 1'b1}},
        '{1'b0, msd_pkg::CH_LT,    1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_SLASH, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_H_LO,  1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_NINE,  1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_GT,    1'b1, 1'b1,
          '{msd_pkg::CH_GT, 1'b0, 1'b1, msd_pkg::KIND_TAG, 1'b1}},
        '{1'b1, 8'hFF,             1'b1, 1'b0, NO_RESULT},
        '{1'b0, 8'h00,             1'b0, 1'b0, NO_RESULT},
        '{1'b0, 8'h00,             1'b0, 1'b0, NO_RESULT},
        '{1'b0, 8'h00,             1'b0, 1'b0, NO_RESULT},
        '{1'b0, 8'h03,             1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_LT,    1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_H_LO,  1'b0, 1'b0, NO_RESULT},
        '{1'b0, msd_pkg::CH_NINE,  1'b0, 1'b0, NO_RESULT},
        '{1'b0, 8'h00,             1'b0, 1'b0, NO_RESULT},
        '{1'b0, 8'h00,             1'b0, 1'b0, NO_RESULT},
        '{1'b0, 8'h00,             1'b1, 1'b0, NO_RESULT},
        '{1'b0, 8'h00,             1'b1, 1'b0, NO_RESULT}
    };

    stim_row_t        link_items [$];     // every slave transaction, in order
    msd_pkg::result_t due_msg_bytes [$];  // message bytes still owed by the block
    msd_pkg::result_t step_bytes [$];     // message bytes caused by the latest item
    int               fail_count = 0;
    int               items_taken = 0;

    // ------------------------------------------------------------------
    // Deframer predictor state
    // ------------------------------------------------------------------
    logic [1:0]  fr_mode = msd_pkg::MODE_UNDECIDED;
    logic [7:0]  head_buf [msd_pkg::HEAD_DEPTH];
    int          head_fill = 0;
    logic [31:0] len_acc = '0;      // shifts in the length, then holds it
    logic [2:0]  len_taken = '0;
    logic [31:0] pay_left = '0;
    logic [2:0]  scan_st = msd_pkg::TS_OUTSIDE;
    logic [1:0]  open_hold = msd_pkg::HOLD_NONE;
    logic        hold_upper = 1'b0;

    function automatic logic letter_h(input logic [7:0] b);
        // 'h' and 'H' differ only in bit 5
        return (b | 8'h20) == msd_pkg::CH_H_LO;
    endfunction

    task automatic emit_byte(input logic [7:0] b, input logic sop, input logic eop,
                             input logic kind);
        msd_pkg::result_t r;
        r.data = b;
        r.sop  = sop;
        r.eop  = eop;
        r.kind = kind;
        r.last = 1'b0;
        step_bytes.push_back(r);
    endtask

    task automatic prefix_take(input logic [7:0] b);
        logic sop;
        logic eop;
        if (len_taken < msd_pkg::LENGTH_BYTES)
        begin
            len_acc = {len_acc[23:0], b};
            len_taken++;
            if (len_taken == msd_pkg::LENGTH_BYTES)
            begin
                pay_left = len_acc & LEN_MASK;
                len_acc  = pay_left;
                // a zero-length frame is skipped: start the next length straight away
                if (pay_left == 0)
                    len_taken = '0;
            end
        end
        else
        begin
            sop = (pay_left == len_acc);
            pay_left--;
            eop = (pay_left == 0);
            emit_byte(b, sop, eop, msd_pkg::KIND_PREFIX);
            if (eop)
            begin
                len_taken = '0;
                len_acc   = '0;
            end
        end
    endtask

    task automatic tag_take(input logic [7:0] b);
        case (scan_st)
            msd_pkg::TS_OUTSIDE:
            begin
                // hold a partial "<h9"; a breaking '<' restarts it, anything else drops it
                if (open_hold == msd_pkg::HOLD_NONE)
                begin
                    if (b == msd_pkg::CH_LT)
                        open_hold = msd_pkg::HOLD_LT;
                end
                else if (open_hold == msd_pkg::HOLD_LT)
                begin
                    if (letter_h(b))
                    begin
                        open_hold  = msd_pkg::HOLD_LT_H;
                        hold_upper = (b == msd_pkg::CH_H_UP);
                    end
                    else if (b != msd_pkg::CH_LT)
                        open_hold = msd_pkg::HOLD_NONE;
                end
                else if (b == msd_pkg::CH_NINE)
                begin
                    emit_byte(msd_pkg::CH_LT, 1'b1, 1'b0, msd_pkg::KIND_TAG);
                    emit_byte(hold_upper ? msd_pkg::CH_H_UP : msd_pkg::CH_H_LO, 1'b0, 1'b0,
                              msd_pkg::KIND_TAG);
                    emit_byte(msd_pkg::CH_NINE, 1'b0, 1'b0, msd_pkg::KIND_TAG);
                    scan_st   = msd_pkg::TS_OPEN;
                    open_hold = msd_pkg::HOLD_NONE;
                end
                else
                    open_hold = (b == msd_pkg::CH_LT) ? msd_pkg::HOLD_LT : msd_pkg::HOLD_NONE;
            end
            msd_pkg::TS_OPEN, msd_pkg::TS_OPEN_SLASH:
            begin
                if (b == msd_pkg::CH_GT)
                begin
                    emit_byte(b, 1'b0, scan_st == msd_pkg::TS_OPEN_SLASH, msd_pkg::KIND_TAG);
                    scan_st = (scan_st == msd_pkg::TS_OPEN_SLASH) ? msd_pkg::TS_OUTSIDE
                                                                  : msd_pkg::TS_BODY;
                end
                else
                begin
                    emit_byte(b, 1'b0, 1'b0, msd_pkg::KIND_TAG);
                    scan_st = (b == msd_pkg::CH_SLASH) ? msd_pkg::TS_OPEN_SLASH
                                                       : msd_pkg::TS_OPEN;
                end
            end
            msd_pkg::TS_WAIT_GT:
            begin
                emit_byte(b, 1'b0, b == msd_pkg::CH_GT, msd_pkg::KIND_TAG);
                if (b == msd_pkg::CH_GT)
                    scan_st = msd_pkg::TS_OUTSIDE;
            end
            default:
            begin
                // body: track a closing "</h9"
                emit_byte(b, 1'b0, 1'b0, msd_pkg::KIND_TAG);
                if (scan_st == msd_pkg::TS_LT && b == msd_pkg::CH_SLASH)
                    scan_st = msd_pkg::TS_LT_SL;
                else if (scan_st == msd_pkg::TS_LT_SL && letter_h(b))
                    scan_st = msd_pkg::TS_LT_SL_H;
                else if (scan_st == msd_pkg::TS_LT_SL_H && b == msd_pkg::CH_NINE)
                    scan_st = msd_pkg::TS_WAIT_GT;
                else
                    scan_st = (b == msd_pkg::CH_LT) ? msd_pkg::TS_LT : msd_pkg::TS_BODY;
            end
        endcase
    endtask

    // Advance the predictor by one item and leave its message bytes in step_bytes
    task automatic deframe_step(input logic close, input logic [7:0] b);
        int i;
        step_bytes.delete();
        if (close)
        begin
            fr_mode    = msd_pkg::MODE_UNDECIDED;
            head_fill  = 0;
            len_acc    = '0;
            len_taken  = '0;
            pay_left   = '0;
            scan_st    = msd_pkg::TS_OUTSIDE;
            open_hold  = msd_pkg::HOLD_NONE;
            hold_upper = 1'b0;
        end
        else if (fr_mode == msd_pkg::MODE_PREFIX)
            prefix_take(b);
        else if (fr_mode == msd_pkg::MODE_TAG)
            tag_take(b);
        else
        begin
            if (head_fill < msd_pkg::HEAD_DEPTH)
            begin
                head_buf[head_fill] = b;
                head_fill++;
            end
            if (head_fill >= msd_pkg::HEAD_DEPTH && head_buf[4] == msd_pkg::CH_LT
                && letter_h(head_buf[5]) && head_buf[6] == msd_pkg::CH_NINE)
                fr_mode = msd_pkg::MODE_PREFIX;
            else if (head_fill >= msd_pkg::HEAD_DEPTH
                     || (head_fill >= 3 && head_buf[0] == msd_pkg::CH_LT
                         && letter_h(head_buf[1]) && head_buf[2] == msd_pkg::CH_NINE))
                fr_mode = msd_pkg::MODE_TAG;
            // replay the held head through the chosen framing
            if (fr_mode != msd_pkg::MODE_UNDECIDED)
            begin
                for (i = 0; i < head_fill; i++)
                begin
                    if (fr_mode == msd_pkg::MODE_PREFIX)
                        prefix_take(head_buf[i]);
                    else
                        tag_take(head_buf[i]);
                end
                head_fill = 0;
            end
        end
        if (step_bytes.size() > 0)
            step_bytes[step_bytes.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Random stimulus builders
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_byte();
        // lean towards the characters that drive the framing logic
        case ($urandom_range(0, 7))
            0: return msd_pkg::CH_LT;
            1: return msd_pkg::CH_GT;
            2: return msd_pkg::CH_SLASH;
            3: return msd_pkg::CH_NINE;
            4: return ($urandom_range(0, 1) != 0) ? msd_pkg::CH_H_UP : msd_pkg::CH_H_LO;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] attr_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == msd_pkg::CH_GT) ? 8'h61 : b;
    endfunction

    task automatic add_item(input logic close, input logic [7:0] b);
        stim_row_t r;
        r       = '0;
        r.close = close;
        r.data  = b;
        link_items.push_back(r);
    endtask

    task automatic add_open_tag();
        add_item(1'b0, msd_pkg::CH_LT);
        add_item(1'b0, ($urandom_range(0, 1) != 0) ? msd_pkg::CH_H_UP : msd_pkg::CH_H_LO);
        add_item(1'b0, msd_pkg::CH_NINE);
    endtask

    // Leading noise, then a self-closing or a closed message with random content
    task automatic add_tag_message();
        int n;
        n = $urandom_range(0, 3);
        repeat (n) add_item(1'b0, pick_byte());
        add_open_tag();
        n = $urandom_range(0, 4);
        repeat (n) add_item(1'b0, attr_byte());
        if ($urandom_range(0, 2) == 0)
        begin
            add_item(1'b0, msd_pkg::CH_SLASH);
            add_item(1'b0, msd_pkg::CH_GT);
        end
        else
        begin
            add_item(1'b0, msd_pkg::CH_GT);
            n = $urandom_range(0, 6);
            repeat (n) add_item(1'b0, ($urandom_range(0, 3) == 0) ? pick_byte() : attr_byte());
            add_item(1'b0, msd_pkg::CH_LT);
            add_item(1'b0, msd_pkg::CH_SLASH);
            add_item(1'b0, ($urandom_range(0, 1) != 0) ? msd_pkg::CH_H_UP : msd_pkg::CH_H_LO);
            add_item(1'b0, msd_pkg::CH_NINE);
            add_item(1'b0, msd_pkg::CH_GT);
        end
    endtask

    // First frame carries "<h9" at bytes 4..6, then short frames, zero lengths among them
    task automatic add_prefix_session();
        int len;
        int k;
        len = $urandom_range(3, 8);
        add_item(1'b0, 8'h00);
        add_item(1'b0, 8'h00);
        add_item(1'b0, 8'h00);
        add_item(1'b0, 8'(len));
        add_open_tag();
        repeat (len - 3) add_item(1'b0, 8'($urandom_range(0, 255)));
        k = $urandom_range(1, 3);
        repeat (k)
        begin
            len = $urandom_range(0, 6);
            add_item(1'b0, 8'h00);
            add_item(1'b0, 8'h00);
            add_item(1'b0, 8'h00);
            add_item(1'b0, 8'(len));
            repeat (len) add_item(1'b0, 8'($urandom_range(0, 255)));
        end
        // now and then cut into the next length before the connection closes
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) add_item(1'b0, pick_byte());
    endtask

    // ------------------------------------------------------------------
    // Sender: reset, build the item list, then offer one transaction at a time
    // ------------------------------------------------------------------
    initial
    begin : sender
        stim_row_t item;
        int        next;
        int        n;

        foreach (directed_rows[r])
            link_items.push_back(directed_rows[r]);
        // each random session opens on a fresh connection
        while (link_items.size() < $size(directed_rows) + RANDOM_ITEMS)
        begin
            add_item(1'b1, 8'($urandom_range(0, 255)));
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) add_tag_message();
                end
                4, 5, 6:
                    add_prefix_session();
                default:
                begin
                    n = $urandom_range(4, 12);
                    repeat (n) add_item(1'b0, pick_byte());
                end
            endcase
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        next = 0;
        while (next < link_items.size())
        begin
            @(posedge clk);
            if (s_axis_tvalid && s_axis_tready)
            begin
                // transaction taken: predict it, or take the hand-typed expectation
                item = link_items[next];
                deframe_step(item.close, item.data);
                if (item.pinned)
                begin
                    if (item.pin_one)
                        due_msg_bytes.push_back(item.pin_res);
                end
                else
                    foreach (step_bytes[k])
                        due_msg_bytes.push_back(step_bytes[k]);
                next++;
                items_taken = next;
            end
            // hold an offer that has not been taken; otherwise choose the next cycle
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (next < link_items.size()
                    && !($urandom_range(0, 99) < IDLE_PCT && !(next >= CALM_FROM
                         && next < CALM_TO)))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= link_items[next].data;
                    s_axis_tuser  <= link_items[next].close;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end

        // drain: wait for every owed byte, then watch for strays
        while (due_msg_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: check each master transaction against the oldest owed byte
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            if (fail_count < REPORT_MAX)
                $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    initial
    begin : receiver
        msd_pkg::result_t want;
        int               results_seen;
        int               hold_left;
        logic             hold_done;

        results_seen = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_msg_bytes.size() == 0)
                begin
                    if (fail_count < REPORT_MAX)
                        $error("unexpected result: out_byte %0h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = due_msg_bytes.pop_front();
                    check_field("out_byte", want.data, m_axis_tdata);
                    check_field("msg_start", 8'(want.sop), 8'(m_axis_tuser[0]));
                    check_field("msg_end", 8'(want.eop), 8'(m_axis_tlast));
                    check_field("framing_kind", 8'(want.kind), 8'(m_axis_tuser[1]));
                    check_field("run_last", 8'(want.last), 8'(m_axis_tuser[2]));
                end
                results_seen++;
            end
            // one long hold-off so the result queue fills and the input stalls
            if (!hold_done && items_taken >= HOLD_AT_ITEM)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (results_seen >= RX_CALM_FROM && results_seen < RX_CALM_TO)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up after a long spell with no transaction on either side
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/msd_pkg.sv
src/message_stream_deframer.sv
src/msd_checker.sv
tb/testbench.sv
